// ===== rtl/smst_pkg.sv =====
// Shared types and codes for the small set membership table.
package smst_pkg;

  // Request opcodes
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  // Fixed field widths
  localparam int POS_W  = 4;
  localparam int ELEM_W = 5;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] value;
  } smst_in_t;

  typedef struct packed {
    logic              found;
    logic [POS_W-1:0]  position;
    logic [1:0]        status;
    logic [ELEM_W-1:0] element_count;
  } smst_out_t;

  // Update strobes broadcast to every cell
  typedef struct packed {
    logic insert_en;
    logic remove_en;
  } smst_ctrl_t;

endpackage

// ===== rtl/small_set_membership_table.sv =====
// Ordered table of signed 32-bit values with lookup, append and remove-first-match;
// each request is compared against every slot of a row of cells and yields one
// result beat, so the block takes one request per clock while not stalled, limited
// by the compare and first-match ripple along the cell row; a removal shifts the
// later entries down one cell as the request is taken. The result is held in an output
// register and a new request is taken while that register is free or being drained.
module small_set_membership_table import smst_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  smst_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output smst_out_t out_data
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  smst_out_t          out_data_r;
  smst_out_t          out_data_nxt;
  logic               accept;
  logic               full;
  logic               found;
  smst_ctrl_t         ctrl;

  logic signed [31:0] cell_data [TABLE_DEPTH];
  logic               seen      [TABLE_DEPTH+1];
  logic [POS_W-1:0]   pos       [TABLE_DEPTH+1];

  // Take a beat unless a finished result is still held
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign full     = count_r == CNT_W'(TABLE_DEPTH);

  assign ctrl.insert_en = accept && (in_data.opcode == OP_INSERT) && !full;
  assign ctrl.remove_en = accept && (in_data.opcode == OP_REMOVE);

  assign seen[0] = 1'b0;
  assign pos[0]  = '0;

  // Row of slots, each but the last fed by its right-hand neighbour on removal
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic signed [31:0] nbr;
    if (g == TABLE_DEPTH - 1) begin : g_last
      assign nbr = cell_data[g];
    end else begin : g_mid
      assign nbr = cell_data[g+1];
    end
    smst_cell #(
      .CNT_W   (CNT_W),
      .CELL_IDX(g)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .value   (in_data.value),
      .count   (count_r),
      .nbr_data(nbr),
      .seen_in (seen[g]),
      .pos_in  (pos[g]),
      .data_out(cell_data[g]),
      .seen_out(seen[g+1]),
      .pos_out (pos[g+1])
    );
  end

  assign found = seen[TABLE_DEPTH];

  // Build the result and the new count
  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    if (accept) begin
      out_valid_nxt       = 1'b1;
      out_data_nxt.found  = found;
      out_data_nxt.status = found ? ST_OK : ST_MISS;
      out_data_nxt.position = pos[TABLE_DEPTH];
      case (in_data.opcode)
        OP_INSERT: begin
          out_data_nxt.status = full ? ST_FULL : ST_OK;
          out_data_nxt.position = full ? '0 : POS_W'(count_r);
          if (!full) begin
            count_nxt = count_r + 1'b1;
          end
        end
        OP_REMOVE: begin
          if (found) begin
            count_nxt = count_r - 1'b1;
          end
        end
        default: begin
        end
      endcase
      out_data_nxt.element_count = ELEM_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/smst_cell.sv =====
// One table slot: holds an entry, matches it and shifts it on removal.
module smst_cell import smst_pkg::*; #(
  parameter int CNT_W    = 5,
  parameter int CELL_IDX = 0
) (
  input  logic               clk,
  input  smst_ctrl_t         ctrl,
  input  logic signed [31:0] value,
  input  logic [CNT_W-1:0]   count,
  input  logic signed [31:0] nbr_data,
  input  logic               seen_in,
  input  logic [POS_W-1:0]   pos_in,
  output logic signed [31:0] data_out,
  output logic               seen_out,
  output logic [POS_W-1:0]   pos_out
);

  logic signed [31:0] data_r;
  logic signed [31:0] data_nxt;
  logic               occupied;
  logic               match;

  // Compare against the request when this slot holds a live entry
  assign occupied = CNT_W'(CELL_IDX) < count;
  assign match    = occupied && (data_r == value);

  // Pass the first-match position down the row
  assign seen_out = seen_in | match;
  assign pos_out  = seen_in ? pos_in : (match ? POS_W'(CELL_IDX) : '0);
  assign data_out = data_r;

  // Load on append, take the neighbour's entry from the match onwards on removal
  always_comb begin
    data_nxt = data_r;
    if (ctrl.insert_en && (count == CNT_W'(CELL_IDX))) begin
      data_nxt = value;
    end else if (ctrl.remove_en && seen_out) begin
      data_nxt = nbr_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the small set membership table: directed and random requests, checked per beat.
`timescale 1ns / 100ps

module tb_top;
  import smst_pkg::*;

  // Run-wide limits and table geometry
  localparam int TABLE_DEPTH  = 16;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 60;
  localparam int REPORT_MAX   = 10;

  // Opcode 3 is unused by the block and behaves as a lookup
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam logic [31:0] MIN_VAL  = 32'h8000_0000;
  localparam logic [31:0] MAX_VAL  = 32'h7fff_ffff;
  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  smst_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  smst_out_t out_data;

  // Shadow copy of the table, updated at each accepted request beat
  logic [31:0] tbl_vals [TABLE_DEPTH];
  int          tbl_count = 0;

  // Answers owed by the block, oldest first
  smst_out_t   pending_answers [$];

  logic [31:0] value_pool [8] = '{MIN_VAL, MAX_VAL, 32'd0, ALL_ONES,
                                  32'd1, 32'h5a5a_5a5a, 32'ha5a5_a5a5, 32'd42};

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_reqs     = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int cycle_cnt     = 0;
  int n_sent        = 0;
  int n_checked     = 0;
  int n_bad         = 0;
  int n_full        = 0;
  int n_miss        = 0;

  small_set_membership_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 10 ns clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one request to the shadow table and return the answer it owes
  function automatic smst_out_t table_apply(smst_in_t req);
    smst_out_t res;
    int        hit;
    hit = -1;
    for (int i = 0; i < tbl_count; i++) begin
      if (hit < 0 && tbl_vals[i] == req.value) hit = i;
    end
    res.found    = (hit >= 0);
    res.position = '0;
    res.status   = ST_OK;
    case (req.opcode)
      OP_INSERT: begin
        if (tbl_count >= TABLE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          res.position        = POS_W'(tbl_count);
          tbl_vals[tbl_count] = req.value;
          tbl_count++;
        end
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          res.position = POS_W'(hit);
          // close the gap, keeping the order of later entries
          for (int i = hit; i < tbl_count - 1; i++) tbl_vals[i] = tbl_vals[i + 1];
          tbl_count--;
        end else begin
          res.status = ST_MISS;
        end
      end
      default: begin
        if (hit >= 0) res.position = POS_W'(hit);
        else res.status = ST_MISS;
      end
    endcase
    res.element_count = ELEM_W'(tbl_count);
    return res;
  endfunction

  // Offer one request beat, idling first at random; valid stays high after acceptance
  task automatic offer_request(input logic [1:0] op, input logic [31:0] val);
    smst_in_t req;
    req.opcode = op;
    req.value  = val;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    pending_answers.push_back(table_apply(req));
    n_sent++;
  endtask

  // Choose a value: mostly stored or pool values so that hits are common
  function automatic logic [31:0] pick_value();
    int roll;
    roll = $urandom_range(99);
    if (roll < 15) return $urandom();
    if (roll < 60 && tbl_count > 0) return tbl_vals[$urandom_range(tbl_count - 1)];
    return value_pool[$urandom_range(7)];
  endfunction

  // Extremes, every opcode, misses on empty, duplicates, full table, shifts
  task automatic test_directed_cases();
    offer_request(OP_LOOKUP, 32'd0);
    offer_request(OP_REMOVE, MAX_VAL);
    offer_request(OP_SPARE, MIN_VAL);
    offer_request(OP_INSERT, MIN_VAL);
    offer_request(OP_INSERT, MAX_VAL);
    offer_request(OP_INSERT, 32'd0);
    offer_request(OP_INSERT, ALL_ONES);
    offer_request(OP_INSERT, MIN_VAL);
    offer_request(OP_LOOKUP, MAX_VAL);
    offer_request(OP_SPARE, ALL_ONES);
    offer_request(OP_LOOKUP, 32'h1234_5678);
    offer_request(OP_REMOVE, MIN_VAL);
    offer_request(OP_LOOKUP, MIN_VAL);
    for (int i = 0; i < 12; i++) offer_request(OP_INSERT, 32'h0100_0000 + i);
    offer_request(OP_INSERT, MAX_VAL);
    offer_request(OP_INSERT, 32'h0bad_0000);
    offer_request(OP_REMOVE, 32'h0100_000b);
    offer_request(OP_REMOVE, MAX_VAL);
  endtask

  // Random traffic in windows that each lean at random towards filling or draining the table
  task automatic test_random_traffic(input int n_items, input int snd_pct, input int rcv_pct);
    int          fill_bias;
    int          roll;
    logic [1:0]  op;
    fill_bias     = 60;
    send_idle_pct = snd_pct;
    recv_idle_pct <= rcv_pct;
    for (int k = 0; k < n_items; k++) begin
      if (k % 40 == 0) fill_bias = $urandom_range(1) ? 60 : 20;
      roll = $urandom_range(99);
      if (roll < 5) op = OP_SPARE;
      else if (roll < 5 + fill_bias) op = OP_INSERT;
      else if (roll < 80) op = OP_REMOVE;
      else op = OP_LOOKUP;
      offer_request(op, pick_value());
    end
  endtask

  // Hold the result side off for a long stretch while requests keep coming
  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_reqs     <= hold_reqs + 1;
    for (int k = 0; k < 70; k++) begin
      offer_request($urandom_range(1) ? OP_INSERT : OP_REMOVE, pick_value());
    end
  endtask

  // Drive result-side stall: a counted hold-off when requested, else random
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_reqs) begin
      out_stall   <= 1'b1;
      hold_left   <= HOLD_CYCLES - 1;
      hold_served <= hold_served + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each result beat with the oldest owed answer
  always @(posedge clk) begin : check_results
    smst_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        if (n_bad < REPORT_MAX)
          $display("[%0t] unexpected result beat: %p", $realtime, out_data);
        n_bad++;
      end else begin
        want = pending_answers.pop_front();
        n_checked++;
        if (out_data.status == ST_FULL) n_full++;
        if (out_data.status == ST_MISS) n_miss++;
        if (out_data.found !== want.found || out_data.position !== want.position ||
            out_data.status !== want.status ||
            out_data.element_count !== want.element_count) begin
          if (n_bad < REPORT_MAX)
            $display("[%0t] result %0d: expected found=%0d pos=%0d st=%0d cnt=%0d, got found=%0d pos=%0d st=%0d cnt=%0d",
                     $realtime, n_checked, want.found, want.position, want.status,
                     want.element_count, out_data.found, out_data.position,
                     out_data.status, out_data.element_count);
          n_bad++;
        end
      end
    end
  end

  // Abort a run that stops making progress
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d answers outstanding",
               cycle_cnt, pending_answers.size());
      $display("small_set_membership_table: mismatch");
      $finish;
    end
  end

  // Sequence the tests
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_traffic(450, 20, 59);
    test_random_traffic(450, 59, 20);
    test_random_traffic(450, 0, 0);
    test_output_hold_off();
    in_valid <= 1'b0;

    // drain owed answers, then allow for any late stray beat
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests sent, %0d results checked (%0d table-full, %0d not-found)",
             n_sent, n_checked, n_full, n_miss);
    $display("covered fill to full, shifts on removal, spare opcode, idling on both sides, %0d errors",
             n_bad);
    if (n_bad == 0 && pending_answers.size() == 0) begin
      $display("small_set_membership_table: match");
    end else begin
      $display("small_set_membership_table: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/smst_pkg.sv
rtl/smst_cell.sv
rtl/small_set_membership_table.sv
tb/tb_top.sv
